// File: rtl/core/rlse_pkg.sv
// ----------------------------------------------------------------------------
// rlse_pkg: shared types and constants of the RGB LED strip encoder
// Operation codes, register indexes, transaction payloads and the bit-pair
// line code used by the modules of the block that need them.
// ----------------------------------------------------------------------------
package rlse_pkg;

  typedef enum logic [1:0] {
    OP_SET_PIXEL = 2'd0,
    OP_CLEAR     = 2'd1,
    OP_START     = 2'd2,
    OP_NEXT_BYTE = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL,
    ST_READ,
    ST_EMIT
  } ctrl_state_e;

  // Register indexes as decoded from paddr[2].
  localparam logic [0:0] REG_RESET_BYTES = 1'b0;
  localparam logic [0:0] REG_STRIP_LEN   = 1'b1;

  localparam logic [7:0] RESET_BYTES_INIT = 8'd200;
  localparam logic [6:0] STRIP_LEN_INIT   = 7'd64;

  // Color order on the line: blue, red, green.
  localparam logic [1:0] COLOR_BLUE  = 2'd0;
  localparam logic [1:0] COLOR_RED   = 2'd1;
  localparam logic [1:0] COLOR_GREEN = 2'd2;

  typedef struct packed {
    op_e        operation;
    logic [5:0] pixel_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_item_t;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       frame_end;
  } out_item_t;

  // Decoded view of the current byte position.
  typedef struct packed {
    logic       in_gap;
    logic       past_end;
    logic       last_byte;
    logic [1:0] color;
    logic [1:0] pair;
  } pos_info_t;

  // Each pair of data bits becomes one line byte.
  function automatic logic [7:0] encode_pair(input logic [1:0] bits);
    logic [7:0] code;
    case (bits)
      2'b00:   code = 8'h88;
      2'b01:   code = 8'h8E;
      2'b10:   code = 8'hE8;
      2'b11:   code = 8'hEE;
      default: code = 8'h88;
    endcase
    return code;
  endfunction

endpackage

// File: rtl/core/rlse_pixel_mem.sv
// ----------------------------------------------------------------------------
// rlse_pixel_mem: pixel frame store
// One write port and one registered read port, one entry of 24 bits per pixel.
// ----------------------------------------------------------------------------
module rlse_pixel_mem #(
  parameter int MAX_PIXELS = 64
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1)-1:0] waddr_i,
  input  logic [23:0]                               wdata_i,
  input  logic [((MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1)-1:0] raddr_i,
  output logic [23:0]                               rdata_o
);

  logic [23:0] store_q [MAX_PIXELS];
  logic [23:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      store_q[waddr_i] <= wdata_i;
    end
    rdata_q <= store_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/rlse_pos_decode.sv
// ----------------------------------------------------------------------------
// rlse_pos_decode: byte position decoder
// Splits the frame byte position into gap, pixel, color and bit pair, and
// flags the last byte of the frame. Division by twelve uses a registered
// reciprocal multiply followed by one correction step.
// ----------------------------------------------------------------------------
module rlse_pos_decode #(
  parameter int MAX_PIXELS = 64
) (
  input  logic                                       clk_i,
  input  logic [$clog2(256 + 12 * MAX_PIXELS)-1:0]   position_i,
  input  logic [7:0]                                 reset_bytes_i,
  input  logic [$clog2(256 + 12 * MAX_PIXELS)-1:0]   len_i,
  output logic [((MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1)-1:0] pix_addr_o,
  output rlse_pkg::pos_info_t                        info_o
);

  localparam int POS_W = $clog2(256 + 12 * MAX_PIXELS);
  localparam int XW    = POS_W - 2;
  localparam int AW    = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam logic [XW-1:0] RECIP = XW'((1 << XW) / 3);

  logic [POS_W-1:0] rb_ext;
  logic [POS_W-1:0] total;
  logic [POS_W-1:0] diff;

  logic [XW-1:0]    x_q;
  logic [2*XW-1:0]  prod_q;
  logic [1:0]       pair_q;
  logic             gap_q;
  logic             past_q;
  logic             last_q;

  logic [XW-1:0]    q0;
  logic [XW-1:0]    three_q0;
  logic [2:0]       rem;
  logic             rem_hi;
  logic [XW-1:0]    pix;
  logic [1:0]       color;

  always_comb begin
    rb_ext = POS_W'(reset_bytes_i);
    total  = rb_ext + (len_i << 3) + (len_i << 2);
    diff   = position_i - rb_ext;
  end

  // The position holds still during a request; the user must hold the config
  // too, unenforced by the block, so these registers track them every cycle.
  always_ff @(posedge clk_i) begin
    x_q    <= diff[POS_W-1:2];
    prod_q <= (2*XW)'(diff[POS_W-1:2]) * (2*XW)'(RECIP);
    pair_q <= diff[1:0];
    gap_q  <= position_i < rb_ext;
    past_q <= position_i >= total;
    last_q <= (position_i + POS_W'(1)) == total;
  end

  // The estimate is low by at most one, so the remainder stays below six.
  always_comb begin
    q0       = prod_q[2*XW-1:XW];
    three_q0 = (q0 << 1) + q0;
    rem      = 3'(x_q - three_q0);
    rem_hi   = rem >= 3'd3;
    pix      = rem_hi ? q0 + XW'(1) : q0;
    color    = rem_hi ? 2'(rem - 3'd3) : rem[1:0];
  end

  assign pix_addr_o       = AW'(pix);
  assign info_o.in_gap    = gap_q;
  assign info_o.past_end  = past_q;
  assign info_o.last_byte = last_q;
  assign info_o.color     = color;
  assign info_o.pair      = pair_q;

endmodule

// File: rtl/core/rlse_ctrl.sv
// ----------------------------------------------------------------------------
// rlse_ctrl: operation sequencer
// Accepts operations, sweeps the frame store for fill and clear, walks the
// frame position and encodes each requested byte into the output register.
// ----------------------------------------------------------------------------
module rlse_ctrl #(
  parameter int MAX_PIXELS = 64
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       in_valid_i,
  output logic                                       in_ready_o,
  input  rlse_pkg::in_item_t                         in_item_i,
  input  logic [$clog2(256 + 12 * MAX_PIXELS)-1:0]   len_i,
  input  rlse_pkg::pos_info_t                        info_i,
  input  logic [23:0]                                rdata_i,
  output logic                                       mem_we_o,
  output logic [((MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1)-1:0] mem_waddr_o,
  output logic [23:0]                                mem_wdata_o,
  output logic [$clog2(256 + 12 * MAX_PIXELS)-1:0]   position_o,
  output logic                                       out_valid_o,
  input  logic                                       out_ready_i,
  output rlse_pkg::out_item_t                        out_item_o
);

  localparam int POS_W = $clog2(256 + 12 * MAX_PIXELS);
  localparam int AW    = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int IW    = (AW > 6) ? AW : 6;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_PIXELS - 1);

  rlse_pkg::ctrl_state_e state_q, state_d;
  logic [AW-1:0]         cnt_q, cnt_d;
  logic                  active_q, active_d;
  logic [POS_W-1:0]      pos_q, pos_d;
  logic                  out_valid_q, out_valid_d;
  rlse_pkg::out_item_t   out_item_q, out_item_d;
  logic [5:0]            fill_last_q, fill_last_d;
  logic [23:0]           fill_word_q, fill_word_d;

  logic [7:0]            color_val;
  logic [1:0]            pair_bits;
  logic [7:0]            emit_byte;
  logic                  emit_end;

  // Encoding of the byte at the current position from the stored pixel.
  always_comb begin
    case (info_i.color)
      rlse_pkg::COLOR_BLUE:  color_val = rdata_i[7:0];
      rlse_pkg::COLOR_RED:   color_val = rdata_i[23:16];
      rlse_pkg::COLOR_GREEN: color_val = rdata_i[15:8];
      default:               color_val = rdata_i[15:8];
    endcase
    case (info_i.pair)
      2'd0:    pair_bits = color_val[7:6];
      2'd1:    pair_bits = color_val[5:4];
      2'd2:    pair_bits = color_val[3:2];
      2'd3:    pair_bits = color_val[1:0];
      default: pair_bits = color_val[1:0];
    endcase
    if (info_i.past_end || info_i.in_gap) begin
      emit_byte = 8'h00;
    end else begin
      emit_byte = rlse_pkg::encode_pair(pair_bits);
    end
    emit_end = info_i.past_end || info_i.last_byte;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    active_d    = active_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_item_d  = out_item_q;
    fill_last_d = fill_last_q;
    fill_word_d = fill_word_q;
    in_ready_o  = 1'b0;
    mem_we_o    = 1'b0;
    mem_wdata_o = 24'h000000;

    case (state_q)
      rlse_pkg::ST_CLEAR: begin
        mem_we_o = 1'b1;
        if (cnt_q == LAST_ADDR) begin
          state_d = rlse_pkg::ST_IDLE;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end
      rlse_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (in_item_i.operation)
            rlse_pkg::OP_SET_PIXEL: begin
              if (POS_W'(in_item_i.pixel_index) < len_i) begin
                state_d     = rlse_pkg::ST_FILL;
                cnt_d       = '0;
                fill_last_d = in_item_i.pixel_index;
                fill_word_d = {in_item_i.red, in_item_i.green, in_item_i.blue};
              end
            end
            rlse_pkg::OP_CLEAR: begin
              state_d = rlse_pkg::ST_CLEAR;
              cnt_d   = '0;
            end
            rlse_pkg::OP_START: begin
              active_d = 1'b1;
              pos_d    = '0;
            end
            rlse_pkg::OP_NEXT_BYTE: begin
              if (active_q) begin
                state_d = rlse_pkg::ST_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      rlse_pkg::ST_FILL: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = fill_word_q;
        if (IW'(cnt_q) == IW'(fill_last_q)) begin
          state_d = rlse_pkg::ST_IDLE;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end
      rlse_pkg::ST_READ: begin
        state_d = rlse_pkg::ST_EMIT;
      end
      rlse_pkg::ST_EMIT: begin
        // Hold the finished byte until the output register can take it.
        if (!out_valid_q || out_ready_i) begin
          out_valid_d          = 1'b1;
          out_item_d.line_byte = emit_byte;
          out_item_d.frame_end = emit_end;
          state_d              = rlse_pkg::ST_IDLE;
          if (emit_end) begin
            active_d = 1'b0;
            pos_d    = '0;
          end else begin
            pos_d = pos_q + POS_W'(1);
          end
        end
      end
      default: begin
        state_d = rlse_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rlse_pkg::ST_CLEAR;
      cnt_q       <= '0;
      active_q    <= 1'b0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      active_q    <= active_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q  <= out_item_d;
    fill_last_q <= fill_last_d;
    fill_word_q <= fill_word_d;
  end

  assign mem_waddr_o = cnt_q;
  assign position_o  = pos_q;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// File: rtl/core/rgb_led_strip_spi_encoder.sv
// ----------------------------------------------------------------------------
// rgb_led_strip_spi_encoder: RGB LED strip serial line encoder
// Frame store of pixels, APB registers and the per-request byte encoder.
// ----------------------------------------------------------------------------
// After reset the block clears its frame store, one pixel per cycle, and keeps
// in_ready_o low until all MAX_PIXELS entries (64 by default) are cleared. A
// next-byte request within a frame passes through acceptance, the registered
// read of the frame store, and the encode into the output register, which
// waits while that register still holds the previous byte; the single read
// port of the frame store and the registered reciprocal divide set these
// steps. A set-pixel fill writes entries 0 to pixel_index and a clear all
// entries, both one entry per cycle. A frame is reset_byte_count zero bytes
// followed by twelve bytes per pixel in blue, red, green order; frame_end marks
// its last byte, and a request outside a frame returns no transaction.
// ----------------------------------------------------------------------------
module rgb_led_strip_spi_encoder #(
  parameter int MAX_PIXELS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rlse_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rlse_pkg::out_item_t out_item_o
);

  localparam int POS_W = $clog2(256 + 12 * MAX_PIXELS);
  localparam int AW    = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

  logic [7:0]          reset_bytes_q;
  logic [6:0]          strip_len_q;
  logic                cfg_write;
  logic [POS_W-1:0]    strip_len_ext;
  logic [POS_W-1:0]    len;
  logic [POS_W-1:0]    position;
  logic [AW-1:0]       pix_addr;
  rlse_pkg::pos_info_t info;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [23:0]         mem_wdata;
  logic [23:0]         mem_rdata;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_bytes_q <= rlse_pkg::RESET_BYTES_INIT;
      strip_len_q   <= rlse_pkg::STRIP_LEN_INIT;
    end else if (cfg_write) begin
      case (paddr[2])
        rlse_pkg::REG_RESET_BYTES: reset_bytes_q <= pwdata[7:0];
        rlse_pkg::REG_STRIP_LEN:   strip_len_q   <= pwdata[6:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      rlse_pkg::REG_RESET_BYTES: prdata = {24'd0, reset_bytes_q};
      rlse_pkg::REG_STRIP_LEN:   prdata = {25'd0, strip_len_q};
      default:                   prdata = 32'd0;
    endcase
  end

  // A length of zero acts as one pixel; anything beyond the store is capped.
  always_comb begin
    strip_len_ext = POS_W'(strip_len_q);
    if (strip_len_q == 7'd0) begin
      len = POS_W'(1);
    end else if (strip_len_ext > POS_W'(MAX_PIXELS)) begin
      len = POS_W'(MAX_PIXELS);
    end else begin
      len = strip_len_ext;
    end
  end

  rlse_pos_decode #(
    .MAX_PIXELS(MAX_PIXELS)
  ) u_pos_decode (
    .clk_i         (clk_i),
    .position_i    (position),
    .reset_bytes_i (reset_bytes_q),
    .len_i         (len),
    .pix_addr_o    (pix_addr),
    .info_o        (info)
  );

  rlse_pixel_mem #(
    .MAX_PIXELS(MAX_PIXELS)
  ) u_pixel_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (pix_addr),
    .rdata_o (mem_rdata)
  );

  rlse_ctrl #(
    .MAX_PIXELS(MAX_PIXELS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .len_i       (len),
    .info_i      (info),
    .rdata_i     (mem_rdata),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .position_o  (position),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // The frame store is only written during a sweep, never while taking input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> !in_ready_o)
    else $error("frame store written while the block takes input");

  // A start-frame rewinds the position to the first byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (in_item_i.operation == rlse_pkg::OP_START))
    |=> (position == '0))
    else $error("start-frame did not rewind the position");

  // Every emitted byte is either a gap byte or one of the four line codes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.line_byte == 8'h00) || (out_item_o.line_byte == 8'h88) ||
                    (out_item_o.line_byte == 8'h8E) || (out_item_o.line_byte == 8'hE8) ||
                    (out_item_o.line_byte == 8'hEE))
    else $error("line byte outside the line code");

  // After the closing byte of a frame the position is back at the start.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.frame_end && !$stable(out_item_o)) |-> (position == '0))
    else $error("position not rewound after the frame end");

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: regression for the RGB LED strip serial line encoder
// Feeds set-pixel, clear, start-frame and next-byte commands over the input
// channel, programs the gap and strip length over APB between phases, and
// checks every line byte against an in-bench model of store and frame state.
// ----------------------------------------------------------------------------
module testbench;

  localparam int NUM_PIXELS   = 64;
  localparam int RANDOM_ITEMS = 950;
  localparam int PHASE_ITEMS  = 120;
  localparam int IDLE_GAP     = 2 * NUM_PIXELS + 16;
  localparam int CYCLE_LIMIT  = 600000;
  localparam logic [7:0] LINE_CODE [4] = '{8'h88, 8'h8E, 8'hE8, 8'hEE};

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [2:0]          paddr       = '0;
  logic [31:0]         pwdata      = '0;
  logic [31:0]         prdata;
  logic                pready;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  rlse_pkg::in_item_t  in_item_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  rlse_pkg::out_item_t out_item_o;

  // Stimulus waiting for the input channel and line bytes still to arrive.
  rlse_pkg::in_item_t  command_queue [$];
  rlse_pkg::out_item_t expected_bytes [$];

  // Model state of the encoder.
  logic [23:0] pix_store [NUM_PIXELS];
  logic        frame_on;
  int unsigned byte_pos;
  logic [7:0]  cfg_gap_bytes;
  logic [6:0]  cfg_strip_len;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned err_count      = 0;
  int unsigned cycle_count    = 0;

  rgb_led_strip_spi_encoder u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("rgb_led_strip_spi_encoder regression: fail");
      $finish;
    end
  end

  function automatic int unsigned pixels_in_use();
    int unsigned n;
    n = cfg_strip_len;
    if (n == 0) n = 1;
    if (n > NUM_PIXELS) n = NUM_PIXELS;
    return n;
  endfunction

  function automatic int unsigned frame_bytes();
    return cfg_gap_bytes + 12 * pixels_in_use();
  endfunction

  // Applies one accepted command to the model and queues the byte it yields.
  task automatic predict_command(input rlse_pkg::in_item_t cmd);
    int unsigned         len, total, d, i, q;
    logic [23:0]         word;
    logic [7:0]          chan;
    rlse_pkg::out_item_t res;
    len   = pixels_in_use();
    total = frame_bytes();
    case (cmd.operation)
      rlse_pkg::OP_SET_PIXEL: begin
        if (cmd.pixel_index < len) begin
          for (i = 0; i <= cmd.pixel_index; i++) pix_store[i] = {cmd.red, cmd.green, cmd.blue};
        end
      end
      rlse_pkg::OP_CLEAR: begin
        for (i = 0; i < NUM_PIXELS; i++) pix_store[i] = '0;
      end
      rlse_pkg::OP_START: begin
        frame_on = 1'b1;
        byte_pos = 0;
      end
      rlse_pkg::OP_NEXT_BYTE: begin
        if (frame_on) begin
          res.line_byte = 8'h00;
          if (byte_pos >= total) begin
            // The frame shrank under the current position: close it at once.
            res.frame_end = 1'b1;
          end else begin
            if (byte_pos >= cfg_gap_bytes) begin
              d    = byte_pos - cfg_gap_bytes;
              word = pix_store[d / 12];
              case (2'((d % 12) / 4))
                rlse_pkg::COLOR_BLUE: chan = word[7:0];
                rlse_pkg::COLOR_RED:  chan = word[23:16];
                default:              chan = word[15:8];
              endcase
              q = d % 4;
              res.line_byte = LINE_CODE[chan[7 - 2 * q -: 2]];
            end
            res.frame_end = (byte_pos + 1 == total);
          end
          if (res.frame_end) begin
            frame_on = 1'b0;
            byte_pos = 0;
          end else begin
            byte_pos++;
          end
          expected_bytes.push_back(res);
        end
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) predict_command(in_item_i);
      if (!in_valid_i || in_ready_o) begin
        if (command_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_item_i  <= command_queue.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    rlse_pkg::out_item_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected transaction: line_byte %0h, frame_end %0d",
                 out_item_o.line_byte, out_item_o.frame_end);
          err_count++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_item_o.line_byte !== want.line_byte) begin
            $error("line_byte: expected %0h, got %0h", want.line_byte, out_item_o.line_byte);
            err_count++;
          end
          if (out_item_o.frame_end !== want.frame_end) begin
            $error("frame_end: expected %0d, got %0d", want.frame_end, out_item_o.frame_end);
            err_count++;
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic push_cmd(input rlse_pkg::op_e op, input logic [5:0] idx,
                          input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    rlse_pkg::in_item_t it;
    it.operation   = op;
    it.pixel_index = idx;
    it.red         = r;
    it.green       = g;
    it.blue        = b;
    command_queue.push_back(it);
  endtask

  task automatic push_rand(input rlse_pkg::op_e op, input logic [5:0] idx);
    push_cmd(op, idx, 8'($urandom()), 8'($urandom()), 8'($urandom()));
  endtask

  task automatic reg_write(input logic [0:0] idx, input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == rlse_pkg::REG_RESET_BYTES) cfg_gap_bytes = value[7:0];
    else cfg_strip_len = value[6:0];
  endtask

  // Upper data bits are random; only the register's own width counts.
  task automatic set_gap(input logic [7:0] v);
    reg_write(rlse_pkg::REG_RESET_BYTES, {24'($urandom()), v});
  endtask

  task automatic set_strip(input logic [6:0] v);
    reg_write(rlse_pkg::REG_STRIP_LEN, {25'($urandom()), v});
  endtask

  // Waits until every command is in and every byte is out, then lets a
  // fill or clear that gives no transaction run to completion.
  task automatic wait_idle();
    while (command_queue.size() != 0 || in_valid_i || expected_bytes.size() != 0)
      @(posedge clk_i);
    repeat (IDLE_GAP) @(posedge clk_i);
  endtask

  task automatic set_mode(input int unsigned mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
      default: begin send_idle_pct = 6; recv_stall_pct = 6; end
    endcase
  endtask

  // One frame with its setup; mostly whole frames, some cut short or
  // restarted, some mixed with arbitrary commands.
  task automatic queue_frame_run(output int unsigned counted);
    int unsigned len, total, kind, cut, k, ins;
    len     = pixels_in_use();
    total   = frame_bytes();
    counted = 0;
    if ($urandom_range(7) == 0) begin
      push_rand(rlse_pkg::OP_CLEAR, 6'($urandom()));
      counted++;
    end
    repeat ($urandom_range(3)) begin
      if ($urandom_range(4) == 0) push_rand(rlse_pkg::OP_SET_PIXEL, 6'($urandom()));
      else push_rand(rlse_pkg::OP_SET_PIXEL, 6'($urandom_range(len - 1)));
      counted++;
    end
    push_rand(rlse_pkg::OP_START, 6'($urandom()));
    counted++;
    kind = $urandom_range(9);
    if (total > 300) kind = 8;
    case (kind)
      7: begin
        cut = $urandom_range(total - 1);
        repeat (cut) push_rand(rlse_pkg::OP_NEXT_BYTE, 6'($urandom()));
        push_rand(rlse_pkg::OP_START, 6'($urandom()));
        repeat (total) push_rand(rlse_pkg::OP_NEXT_BYTE, 6'($urandom()));
        counted += cut + 1 + total;
      end
      8: begin
        cut = $urandom_range(1, (total > 120) ? 120 : total - 1);
        repeat (cut) push_rand(rlse_pkg::OP_NEXT_BYTE, 6'($urandom()));
        counted += cut;
      end
      9: begin
        repeat ($urandom_range(1, 6)) begin
          push_rand(rlse_pkg::op_e'($urandom_range(3)), 6'($urandom()));
          counted++;
        end
        repeat (total / 2) push_rand(rlse_pkg::OP_NEXT_BYTE, 6'($urandom()));
        counted += total / 2;
      end
      default: begin
        // Now and then the store changes while the frame is on the line.
        ins = ($urandom_range(3) == 0) ? $urandom_range(total - 1) : total;
        for (k = 0; k < total; k++) begin
          if (k == ins) begin
            push_rand(rlse_pkg::OP_SET_PIXEL, 6'($urandom_range(len - 1)));
            counted++;
          end
          push_rand(rlse_pkg::OP_NEXT_BYTE, 6'($urandom()));
        end
        counted += total;
        // Requests after the frame has ended are answered by nothing.
        repeat ($urandom_range(2)) push_rand(rlse_pkg::OP_NEXT_BYTE, 6'($urandom()));
      end
    endcase
  endtask

  initial begin
    int unsigned phase, random_count, phase_count, n, gap, strip;
    for (int i = 0; i < NUM_PIXELS; i++) pix_store[i] = '0;
    frame_on      = 1'b0;
    byte_pos      = 0;
    cfg_gap_bytes = rlse_pkg::RESET_BYTES_INIT;
    cfg_strip_len = rlse_pkg::STRIP_LEN_INIT;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: two pixels after a one-byte gap.
    wait_idle();
    set_gap(8'd1);
    set_strip(7'd2);
    set_mode(0);
    push_cmd(rlse_pkg::OP_NEXT_BYTE, 6'h3F, 8'hFF, 8'hFF, 8'hFF);
    push_cmd(rlse_pkg::OP_SET_PIXEL, 6'd1, 8'h00, 8'hFF, 8'h1B);
    push_cmd(rlse_pkg::OP_SET_PIXEL, 6'd0, 8'hE4, 8'h5A, 8'hFF);
    push_cmd(rlse_pkg::OP_SET_PIXEL, 6'd63, 8'hFF, 8'hFF, 8'hFF);
    push_cmd(rlse_pkg::OP_SET_PIXEL, 6'd2, 8'h00, 8'h00, 8'h00);
    push_cmd(rlse_pkg::OP_START, 6'h00, 8'h00, 8'h00, 8'h00);
    repeat (2) push_rand(rlse_pkg::OP_NEXT_BYTE, 6'($urandom()));
    push_cmd(rlse_pkg::OP_START, 6'h3F, 8'hFF, 8'hFF, 8'hFF);
    repeat (14) push_rand(rlse_pkg::OP_NEXT_BYTE, 6'($urandom()));
    wait_idle();
    // Shrinking the strip leaves the position beyond the new frame length.
    set_strip(7'd1);
    push_cmd(rlse_pkg::OP_NEXT_BYTE, 6'h00, 8'h00, 8'h00, 8'h00);
    push_cmd(rlse_pkg::OP_NEXT_BYTE, 6'h00, 8'h00, 8'h00, 8'h00);
    push_cmd(rlse_pkg::OP_CLEAR, 6'h00, 8'h00, 8'h00, 8'h00);

    phase        = 0;
    random_count = 0;
    while (random_count < RANDOM_ITEMS) begin
      wait_idle();
      case (phase)
        1: begin gap = 255; strip = 0;   end
        2: begin gap = 0;   strip = 127; end
        3: begin gap = 0;   strip = 1;   end
        4: begin gap = 2;   strip = 64;  end
        default: begin
          gap   = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(6);
          strip = ($urandom_range(7) == 0) ? $urandom_range(127) : $urandom_range(4);
        end
      endcase
      set_gap(8'(gap));
      if (phase < 5 || $urandom_range(3) != 0) set_strip(7'(strip));
      set_mode(phase % 4);
      phase_count = 0;
      while (phase_count < PHASE_ITEMS) begin
        queue_frame_run(n);
        phase_count += n;
      end
      random_count += phase_count;
      phase++;
    end

    wait_idle();
    if (err_count == 0) begin
      $display("rgb_led_strip_spi_encoder regression: pass");
    end else begin
      $display("rgb_led_strip_spi_encoder regression: fail");
    end
    $finish;
  end

endmodule
